FILE: rtl/sync_marker_pixel_frame_receiver_assert.svh
// assertion macros used by the frame receiver top level
`ifndef SYNC_MARKER_PIXEL_FRAME_RECEIVER_ASSERT_SVH
`define SYNC_MARKER_PIXEL_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SMPFR_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SMPFR_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/smpfr_pkg.sv
// shared constants and types of the sync marker pixel frame receiver
package smpfr_pkg;

  localparam int BYTE_W     = 8;
  localparam int PIX_W      = 16;
  localparam int POS_W      = 10;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int MATCH_W    = 3;
  localparam int MARKER_LEN = 5;

  localparam int MAX_SIDE_DEF = 1024;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd320;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd240;

  // control from the top level to the pixel assembler
  typedef struct packed {
    logic step;   // a byte is consumed while receiving
    logic start;  // marker just completed, clear frame position
  } pix_ctrl_t;

  // pixel assembler outcome for the byte in the input register
  typedef struct packed {
    logic             emit;       // this byte completes a pixel
    logic             frame_end;  // completed pixel is the last of the frame
    logic [PIX_W-1:0] pixel_word;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
  } pix_res_t;

endpackage

FILE: rtl/sync_marker_pixel_frame_receiver.sv
// top level of the sync marker pixel frame receiver
// path: an accepted item is registered in the input register and decoded there; a pixel it
//   completes is loaded into the result register and shown on out_valid
// throughput: one item per cycle; a held result stalls only an item that completes a pixel
// reset: synchronous active low; block hunts for the marker, frame size 320 x 240
module sync_marker_pixel_frame_receiver #(
  parameter int MAX_SIDE = smpfr_pkg::MAX_SIDE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // byte input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [smpfr_pkg::BYTE_W-1:0]    in_rx_byte,
  // pixel output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [smpfr_pkg::PIX_W-1:0]     out_pixel_word,
  output logic [smpfr_pkg::POS_W-1:0]     out_column,
  output logic [smpfr_pkg::POS_W-1:0]     out_row,
  output logic                           out_frame_end,
  // register writes
  input  logic                           cfg_wr_en,
  input  logic [smpfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [smpfr_pkg::CFG_W-1:0]     cfg_data
);
  import smpfr_pkg::*;

`include "sync_marker_pixel_frame_receiver_assert.svh"

  // size registers
  logic [CFG_W-1:0] frame_width_r;
  logic [CFG_W-1:0] frame_height_r;

  // input register
  logic              in_vld_r;
  logic              in_vld_nxt;
  logic [BYTE_W-1:0] in_byte_r;

  // hunting / receiving mode
  logic receiving_r;
  logic receiving_nxt;

  // result register
  logic              out_vld_r;
  logic              out_vld_nxt;
  logic [PIX_W-1:0]  out_pix_r;
  logic [POS_W-1:0]  out_col_r;
  logic [POS_W-1:0]  out_row_r;
  logic              out_end_r;

  logic      hit;
  logic      produce;
  logic      advance;
  logic      load_out;
  pix_ctrl_t pctl;
  pix_res_t  pres;

  // the held byte yields a pixel only in receiving mode on the second byte
  assign produce = receiving_r && pres.emit;
  // held byte moves on unless its pixel has nowhere to go
  assign advance  = in_vld_r && (!produce || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;
  assign load_out = advance && produce;

  assign pctl.step  = advance && receiving_r;
  assign pctl.start = advance && !receiving_r && hit;

  smpfr_hunt u_hunt (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance && !receiving_r),
    .rx_byte (in_byte_r),
    .hit     (hit)
  );

  smpfr_pixel #(
    .MAX_SIDE (MAX_SIDE)
  ) u_pixel (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (pctl),
    .rx_byte      (in_byte_r),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .res          (pres)
  );

  // mode: marker enters receiving, last pixel of the frame returns to hunting
  always_comb begin
    receiving_nxt = receiving_r;
    if (pctl.start) begin
      receiving_nxt = 1'b1;
    end else if (load_out && pres.frame_end) begin
      receiving_nxt = 1'b0;
    end
  end

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (load_out) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      in_vld_r       <= 1'b0;
      receiving_r    <= 1'b0;
      out_vld_r      <= 1'b0;
    end else begin
      in_vld_r    <= in_vld_nxt;
      receiving_r <= receiving_nxt;
      out_vld_r   <= out_vld_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
          REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
    if (load_out) begin
      out_pix_r <= pres.pixel_word;
      out_col_r <= pres.column;
      out_row_r <= pres.row;
      out_end_r <= pres.frame_end;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_pixel_word = out_pix_r;
  assign out_column     = out_col_r;
  assign out_row        = out_row_r;
  assign out_frame_end  = out_end_r;

  // half-built pixel only exists while receiving
  `SMPFR_ASSERT_NOW(a_pair_only_receiving, clk, rst_n, pres.emit, receiving_r, "pixel pairing while hunting")
  // marker completion switches to receiving with a fresh pair
  `SMPFR_ASSERT_NEXT(a_marker_starts, clk, rst_n, pctl.start, receiving_r && !pres.emit, "marker did not start frame")
  // last pixel of the frame drops back to hunting
  `SMPFR_ASSERT_NEXT(a_end_hunts, clk, rst_n, load_out && pres.frame_end, !receiving_r, "frame end did not resume hunt")
  // a loaded result is always presented
  `SMPFR_ASSERT_NEXT(a_load_shows, clk, rst_n, load_out, out_valid, "loaded pixel not shown")

endmodule

FILE: rtl/smpfr_hunt.sv
// marker matcher: tracks how much of the start marker has been seen
module smpfr_hunt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [smpfr_pkg::BYTE_W-1:0] rx_byte,
  output logic                        hit
);
  import smpfr_pkg::*;

  logic [MATCH_W-1:0] match_r;
  logic [MATCH_W-1:0] match_nxt;
  logic [MATCH_W-1:0] advanced;

  // ascii START
  function automatic logic [BYTE_W-1:0] marker_char(input logic [MATCH_W-1:0] idx);
    logic [BYTE_W-1:0] ch;
    case (idx)
      3'd0:    ch = 8'h53;
      3'd1:    ch = 8'h54;
      3'd2:    ch = 8'h41;
      3'd3:    ch = 8'h52;
      3'd4:    ch = 8'h54;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  always_comb begin
    if ((match_r < MATCH_W'(MARKER_LEN)) && (rx_byte == marker_char(match_r))) begin
      advanced = match_r + MATCH_W'(1);
    end else if (rx_byte == marker_char(MATCH_W'(0))) begin
      // mismatch restarts, but the byte may itself open the marker
      advanced = MATCH_W'(1);
    end else begin
      advanced = '0;
    end
  end

  assign hit = (advanced == MATCH_W'(MARKER_LEN));

  always_comb begin
    match_nxt = match_r;
    if (step) begin
      match_nxt = hit ? '0 : advanced;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= '0;
    end else begin
      match_r <= match_nxt;
    end
  end

endmodule

FILE: rtl/smpfr_pixel.sv
// pixel assembler: pairs bytes into pixels and walks the frame position
module smpfr_pixel #(
  parameter int MAX_SIDE = smpfr_pkg::MAX_SIDE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  smpfr_pkg::pix_ctrl_t        ctrl,
  input  logic [smpfr_pkg::BYTE_W-1:0] rx_byte,
  input  logic [smpfr_pkg::CFG_W-1:0]  frame_width,
  input  logic [smpfr_pkg::CFG_W-1:0]  frame_height,
  output smpfr_pkg::pix_res_t         res
);
  import smpfr_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CMP_W  = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;

  logic [BYTE_W-1:0] high_r;
  logic [BYTE_W-1:0] high_nxt;
  logic              second_r;
  logic              second_nxt;
  logic [CNT_W-1:0]  col_r;
  logic [CNT_W-1:0]  col_nxt;
  logic [CNT_W-1:0]  row_r;
  logic [CNT_W-1:0]  row_nxt;

  logic [SIDE_W-1:0] width_eff;
  logic [SIDE_W-1:0] height_eff;
  logic [SIDE_W-1:0] col_inc;
  logic [SIDE_W-1:0] row_inc;
  logic              last_col;
  logic              last_pix;

  // zero reads as one, oversize clamps to the largest side
  function automatic logic [SIDE_W-1:0] eff_side(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] ext;
    logic [SIDE_W-1:0] side;
    ext = CMP_W'(v);
    if (ext == '0) begin
      side = SIDE_W'(1);
    end else if (ext > CMP_W'(MAX_SIDE)) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = SIDE_W'(ext);
    end
    return side;
  endfunction

  assign width_eff  = eff_side(frame_width);
  assign height_eff = eff_side(frame_height);
  assign col_inc    = SIDE_W'(col_r) + SIDE_W'(1);
  assign row_inc    = SIDE_W'(row_r) + SIDE_W'(1);
  assign last_col   = (col_inc >= width_eff);
  assign last_pix   = last_col && (row_inc >= height_eff);

  assign res.emit       = second_r;
  assign res.frame_end  = last_pix;
  assign res.pixel_word = {high_r, rx_byte};
  assign res.column     = POS_W'(col_r);
  assign res.row        = POS_W'(row_r);

  always_comb begin
    high_nxt   = high_r;
    second_nxt = second_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (ctrl.start) begin
      second_nxt = 1'b0;
      col_nxt    = '0;
      row_nxt    = '0;
    end else if (ctrl.step) begin
      if (!second_r) begin
        high_nxt   = rx_byte;
        second_nxt = 1'b1;
      end else begin
        second_nxt = 1'b0;
        if (last_pix) begin
          col_nxt = '0;
          row_nxt = '0;
        end else if (last_col) begin
          col_nxt = '0;
          row_nxt = CNT_W'(row_inc);
        end else begin
          col_nxt = CNT_W'(col_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      second_r <= second_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    high_r <= high_nxt;
  end

endmodule
